@@ sv/cmx_pkg.sv @@
package cmx_pkg;

  localparam int unsigned SLOT_COUNT = 12;
  localparam int unsigned PIN_COUNT  = 6;
  localparam int unsigned COL_COUNT  = 4;

  typedef logic [3:0]  slot_t;
  typedef logic [11:0] mask_t;
  typedef logic [PIN_COUNT-1:0] pin_t;
  typedef logic [2:0]  pin_idx_t;
  typedef logic [15:0] dwell_t;

  localparam slot_t LAST_SLOT = slot_t'(SLOT_COUNT - 1);

  // Charlieplex pin pairs per LED slot, zero-based pin numbers
  localparam pin_idx_t PAIR_A [SLOT_COUNT] = '{
    3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4
  };
  localparam pin_idx_t PAIR_B [SLOT_COUNT] = '{
    3'd1, 3'd2, 3'd3, 3'd2, 3'd3, 3'd4, 3'd3, 3'd4, 3'd5, 3'd4, 3'd5, 3'd5
  };

  typedef struct packed {
    logic [2:0] row_levels;
    logic [3:0] active_step;
    logic       load_valid;
    mask_t      load_mask;
  } in_item_t;

  typedef struct packed {
    pin_t       pin_enable;
    pin_t       pin_level;
    logic [3:0] column_drive;
    mask_t      step_mask;
    logic       save_touch;
  } out_item_t;

endpackage

@@ sv/cmx_if.sv @@
interface cmx_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  row_levels;
  logic [3:0]  active_step;
  logic        load_valid;
  logic [11:0] load_mask;

  modport source (output valid, output row_levels, output active_step,
                  output load_valid, output load_mask, input ready);
  modport sink   (input valid, input row_levels, input active_step,
                  input load_valid, input load_mask, output ready);
endinterface

interface cmx_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  pin_enable;
  logic [5:0]  pin_level;
  logic [3:0]  column_drive;
  logic [11:0] step_mask;
  logic        save_touch;

  modport source (output valid, output pin_enable, output pin_level,
                  output column_drive, output step_mask, output save_touch,
                  input ready);
  modport sink   (input valid, input pin_enable, input pin_level,
                  input column_drive, input step_mask, input save_touch,
                  output ready);
endinterface

@@ sv/cmx_step.sv @@
module cmx_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               advance,
  input  cmx_pkg::in_item_t  item,
  output cmx_pkg::out_item_t result
);

  cmx_pkg::dwell_t dwell_r;
  cmx_pkg::mask_t  mask_r, mask_nxt;
  cmx_pkg::slot_t  led_slot_r, led_slot_nxt;
  cmx_pkg::dwell_t dwell_cnt_r, dwell_cnt_nxt;
  cmx_pkg::slot_t  key_slot_r, key_slot_nxt;
  cmx_pkg::mask_t  hist_r, hist_nxt;

  cmx_pkg::mask_t  mask_load;
  cmx_pkg::slot_t  k;
  cmx_pkg::slot_t  s;
  logic [1:0]      row;
  logic            pressed;
  cmx_pkg::mask_t  key_bit;
  cmx_pkg::pin_t   pin_a, pin_b;
  cmx_pkg::dwell_t dwell_eff;
  logic [16:0]     cnt_inc;
  logic            save_c;
  logic [3:0]      col_c;
  cmx_pkg::pin_t   led_en, led_lvl;

  // Key scan: toggle the step bit on a new press
  always_comb begin
    mask_load = item.load_valid ? item.load_mask : mask_r;
    k         = (key_slot_r > cmx_pkg::LAST_SLOT) ? '0 : key_slot_r;
    row       = k[3:2];
    pressed   = ~item.row_levels[row];
    key_bit   = cmx_pkg::mask_t'(1) << k;
    hist_nxt  = pressed ? (hist_r | key_bit) : (hist_r & ~key_bit);
    if (pressed && !hist_r[k]) begin
      mask_nxt = mask_load ^ key_bit;
      save_c   = 1'b1;
    end else begin
      mask_nxt = mask_load;
      save_c   = 1'b0;
    end
    key_slot_nxt = (k == cmx_pkg::LAST_SLOT) ? '0 : k + 4'd1;
    col_c        = ~(4'b0001 << key_slot_nxt[1:0]);
  end

  // LED drive from the updated mask
  always_comb begin
    s     = (led_slot_r > cmx_pkg::LAST_SLOT) ? '0 : led_slot_r;
    pin_a = cmx_pkg::pin_t'(1) << cmx_pkg::PAIR_A[s];
    pin_b = cmx_pkg::pin_t'(1) << cmx_pkg::PAIR_B[s];
    if (item.active_step == s) begin
      led_en  = pin_a | pin_b;
      led_lvl = pin_a;
    end else if (mask_nxt[s]) begin
      led_en  = pin_a | pin_b;
      led_lvl = pin_b;
    end else begin
      led_en  = '0;
      led_lvl = '0;
    end
  end

  // Pack the result fields
  assign result = {led_en, led_lvl, col_c, mask_nxt, save_c};

  // Dwell timing: advance the slot once the count reaches the dwell
  always_comb begin
    dwell_eff = (dwell_r == '0) ? 16'd1 : dwell_r;
    cnt_inc   = {1'b0, dwell_cnt_r} + 17'd1;
    if (cnt_inc >= {1'b0, dwell_eff}) begin
      dwell_cnt_nxt = '0;
      led_slot_nxt  = (s == cmx_pkg::LAST_SLOT) ? '0 : s + 4'd1;
    end else begin
      dwell_cnt_nxt = cnt_inc[15:0];
      led_slot_nxt  = s;
    end
  end

  // Commit state on each item that moves to the result register; load the dwell on cfg_we
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell_r     <= 16'd1;
      mask_r      <= '1;
      led_slot_r  <= '0;
      dwell_cnt_r <= '0;
      key_slot_r  <= '0;
      hist_r      <= '0;
    end else begin
      if (cfg_we) begin
        dwell_r <= cfg_wdata;
      end
      if (advance) begin
        mask_r      <= mask_nxt;
        led_slot_r  <= led_slot_nxt;
        dwell_cnt_r <= dwell_cnt_nxt;
        key_slot_r  <= key_slot_nxt;
        hist_r      <= hist_nxt;
      end
    end
  end

endmodule

@@ sv/charlieplex_led_and_key_matrix_scan.sv @@
// Path: each item passes the input register, then the result register, to out_ch.
// Throughput: one item per cycle while out_ch is not stalled; the per-tick update is a
// single pass of logic between the two registers. Input stalls only while out_ch is stalled.
// Reset (rst_n low, synchronous): both stages empty, mask all ones, slots,
// dwell count and key history zero, dwell_r 1.
module charlieplex_led_and_key_matrix_scan (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  cmx_in_if.sink      in_ch,
  cmx_out_if.source   out_ch
);

  logic               in_valid_r;
  cmx_pkg::in_item_t  in_item_r;
  logic               out_valid_r;
  cmx_pkg::out_item_t out_item_r;
  cmx_pkg::out_item_t result;
  logic               advance;

  // Move the held item forward when the result register is free
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_item_r.row_levels  <= in_ch.row_levels;
      in_item_r.active_step <= in_ch.active_step;
      in_item_r.load_valid  <= in_ch.load_valid;
      in_item_r.load_mask   <= in_ch.load_mask;
    end
  end

  cmx_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .advance   (advance),
    .item      (in_item_r),
    .result    (result)
  );

  // Result register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pin_enable   = out_item_r.pin_enable;
  assign out_ch.pin_level    = out_item_r.pin_level;
  assign out_ch.column_drive = out_item_r.column_drive;
  assign out_ch.step_mask    = out_item_r.step_mask;
  assign out_ch.save_touch   = out_item_r.save_touch;

endmodule

@@ sv/cmx_checker.sv @@
module cmx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  pin_enable,
  input logic [5:0]  pin_level,
  input logic [3:0]  column_drive,
  input logic [11:0] step_mask,
  input logic        save_touch
);

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pin_enable) &&
      $stable(pin_level) && $stable(column_drive) && $stable(step_mask) &&
      $stable(save_touch))
    else $error("result changed while stalled");

  // Exactly one key column driven low
  a_one_column: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones(~column_drive) == 1)
    else $error("column drive not one-cold");

  // An LED lights across exactly one pin pair or the pins float
  a_pin_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones(pin_enable) == 2 || pin_enable == 6'd0))
    else $error("bad pin enable pattern");

  // A pin is high only where it is driven, and exactly one driven pin is high
  a_pin_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((pin_level & ~pin_enable) == 6'd0) &&
      ((pin_enable == 6'd0) || $countones(pin_level) == 1))
    else $error("pin level outside driven pair");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind charlieplex_led_and_key_matrix_scan cmx_checker u_cmx_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .pin_enable   (out_ch.pin_enable),
  .pin_level    (out_ch.pin_level),
  .column_drive (out_ch.column_drive),
  .step_mask    (out_ch.step_mask),
  .save_touch   (out_ch.save_touch)
);

@@ verif/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  cmx_pkg::dwell_t cfg_wdata;

  cmx_in_if  in_ch ();
  cmx_out_if out_ch ();

  charlieplex_led_and_key_matrix_scan uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Scanner state as the block should hold it
  cmx_pkg::mask_t  step_bits  = 12'hfff;
  cmx_pkg::slot_t  led_pos    = '0;
  cmx_pkg::dwell_t dwell_cnt  = '0;
  cmx_pkg::slot_t  key_pos    = '0;
  cmx_pkg::mask_t  key_seen   = '0;
  cmx_pkg::dwell_t dwell_cfg  = 16'd1;

  cmx_pkg::in_item_t  tick_queue [$];
  cmx_pkg::out_item_t led_frames_due [$];
  cmx_pkg::in_item_t  held_item;
  int                 idle_pct   = 19;
  int                 fail_count = 0;

  // Stimulus bookkeeping: key slot of the next queued tick, keys held down
  int             gen_key  = 0;
  cmx_pkg::mask_t held     = '0;
  int             play_pos = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Compute the result of one scan tick and advance the state
  function automatic cmx_pkg::out_item_t scan_tick(cmx_pkg::in_item_t it);
    cmx_pkg::out_item_t r;
    cmx_pkg::slot_t     k;
    cmx_pkg::slot_t     s;
    logic               pressed;
    cmx_pkg::pin_idx_t  a;
    cmx_pkg::pin_idx_t  b;
    logic [16:0]        lim;
    r = '0;
    if (it.load_valid) step_bits = it.load_mask;

    // Sample the current key; only a new press toggles its step
    k = (key_pos < cmx_pkg::SLOT_COUNT) ? key_pos : '0;
    pressed = ~it.row_levels[k[3:2]];
    if (pressed != key_seen[k]) begin
      key_seen[k] = pressed;
      if (pressed) begin
        step_bits[k] = ~step_bits[k];
        r.save_touch = 1'b1;
      end
    end
    key_pos = (k == cmx_pkg::LAST_SLOT) ? cmx_pkg::slot_t'(0) : cmx_pkg::slot_t'(k + 1);

    // Drive the LED slot from the updated mask
    s = (led_pos < cmx_pkg::SLOT_COUNT) ? led_pos : '0;
    a = cmx_pkg::PAIR_A[s];
    b = cmx_pkg::PAIR_B[s];
    if (it.active_step == s) begin
      r.pin_enable[a] = 1'b1;
      r.pin_enable[b] = 1'b1;
      r.pin_level[a]  = 1'b1;
    end else if (step_bits[s]) begin
      r.pin_enable[a] = 1'b1;
      r.pin_enable[b] = 1'b1;
      r.pin_level[b]  = 1'b1;
    end

    // Advance the slot once the dwell is spent; zero acts as one
    lim = (dwell_cfg == 0) ? 17'd1 : {1'b0, dwell_cfg};
    if ({1'b0, dwell_cnt} + 17'd1 >= lim) begin
      dwell_cnt = '0;
      led_pos = (s == cmx_pkg::LAST_SLOT) ? cmx_pkg::slot_t'(0) : cmx_pkg::slot_t'(s + 1);
    end else begin
      dwell_cnt = dwell_cnt + 16'd1;
      led_pos = s;
    end

    r.column_drive = ~(4'b0001 << key_pos[1:0]);
    r.step_mask    = step_bits;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp, act);
      fail_count++;
    end
  endfunction

  // Driver: present queued ticks, predict each one on its transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        led_frames_due.push_back(scan_tick(held_item));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tick_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
          held_item = tick_queue.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.row_levels  <= held_item.row_levels;
          in_ch.active_step <= held_item.active_step;
          in_ch.load_valid  <= held_item.load_valid;
          in_ch.load_mask   <= held_item.load_mask;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer against the oldest prediction
  always @(posedge clk) begin
    cmx_pkg::out_item_t exp;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (led_frames_due.size() == 0) begin
        $error("result transfer with no prediction pending");
        fail_count++;
      end else begin
        exp = led_frames_due.pop_front();
        check_field("pin_enable", exp.pin_enable, out_ch.pin_enable);
        check_field("pin_level", exp.pin_level, out_ch.pin_level);
        check_field("column_drive", exp.column_drive, out_ch.column_drive);
        check_field("step_mask", exp.step_mask, out_ch.step_mask);
        check_field("save_touch", exp.save_touch, out_ch.save_touch);
      end
    end
    out_ch.ready <= ($urandom_range(99) >= idle_pct);
  end

  task automatic queue_tick(logic [2:0] rows, logic [3:0] act, logic lv, cmx_pkg::mask_t lm);
    cmx_pkg::in_item_t it;
    it.row_levels  = rows;
    it.active_step = act;
    it.load_valid  = lv;
    it.load_mask   = lm;
    tick_queue.push_back(it);
    gen_key = (gen_key == cmx_pkg::SLOT_COUNT - 1) ? 0 : gen_key + 1;
  endtask

  // Hold until every queued tick has been transferred and checked
  task automatic wait_drained();
    while (tick_queue.size() != 0 || led_frames_due.size() != 0 || in_ch.valid)
      @(negedge clk);
  endtask

  task automatic write_dwell(cmx_pkg::dwell_t v);
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    dwell_cfg = v;
    @(negedge clk);
  endtask

  // Mostly matrix-consistent rows from a held-key set, with some noise
  task automatic queue_random(int n);
    int         col;
    logic [2:0] rows;
    logic [3:0] act;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 4) held[4'($urandom_range(11))] ^= 1'b1;
      col  = gen_key % cmx_pkg::COL_COUNT;
      rows = {~held[4'(8 + col)], ~held[4'(4 + col)], ~held[4'(col)]};
      if ($urandom_range(99) < 8) rows = 3'($urandom_range(7));
      act = ($urandom_range(99) < 75) ? 4'(play_pos) : 4'($urandom_range(15));
      if ($urandom_range(3) == 0) begin
        play_pos = (play_pos == cmx_pkg::SLOT_COUNT - 1) ? 0 : play_pos + 1;
      end
      queue_tick(rows, act, ($urandom_range(99) < 6),
                 cmx_pkg::mask_t'($urandom_range(4095)));
    end
  endtask

  initial begin
    cmx_pkg::dwell_t plan [8];
    plan = '{16'hffff, 16'd1, 16'd3, 16'd0, 16'd7, 16'd2, 16'd12, 16'd1};
    plan[4] = cmx_pkg::dwell_t'($urandom_range(16, 1));
    clk         = 1'b0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_ch.valid = 1'b0;
    in_ch.row_levels  = '0;
    in_ch.active_step = '0;
    in_ch.load_valid  = 1'b0;
    in_ch.load_mask   = '0;
    out_ch.ready      = 1'b1;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: colour 1 at slot 0, empty and full loads, no active step
    queue_tick(3'b111, 4'd0, 1'b0, 12'h000);
    queue_tick(3'b111, 4'd15, 1'b1, 12'h000);
    queue_tick(3'b111, 4'd12, 1'b1, 12'hfff);
    queue_tick(3'b111, 4'd3, 1'b0, 12'h000);
    // Press every key, then release
    for (int i = 0; i < cmx_pkg::SLOT_COUNT; i++) queue_tick(3'b000, 4'(i), 1'b0, 12'h000);
    queue_tick(3'b111, 4'd13, 1'b0, 12'h000);
    queue_tick(3'b111, 4'd14, 1'b0, 12'h000);

    // Zero dwell behaves as one
    write_dwell(16'd0);
    queue_tick(3'b101, 4'd11, 1'b0, 12'h000);
    queue_tick(3'b010, 4'd11, 1'b1, 12'h5a5);

    // Lower the dwell after the count has passed the new limit
    write_dwell(16'd5);
    for (int i = 0; i < 3; i++) queue_tick(3'b111, 4'd12, 1'b0, 12'h000);
    write_dwell(16'd2);
    for (int i = 0; i < 3; i++) queue_tick(3'b111, 4'd12, 1'b0, 12'h000);

    // Random phases across several dwell settings, one without idling
    for (int p = 0; p < 8; p++) begin
      write_dwell(plan[p]);
      idle_pct = (p == 6) ? 0 : 19;
      queue_random(232);
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
